### sv/drff_pkg.sv
package drff_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 320;
   localparam int MAX_HEIGHT_DEFAULT = 240;

   // Field widths fixed by the interface
   localparam int XW     = 9;
   localparam int YW     = 8;
   localparam int POS_W  = 16;
   localparam int COLOR_W = 32;
   localparam int PIX_W  = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [XW-1:0] FRAME_WIDTH_RESET  = XW'(320);
   localparam logic [YW-1:0] FRAME_HEIGHT_RESET = YW'(240);

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_FLUSH = 2'd1,
      KIND_TICK  = 2'd2,
      KIND_NONE  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      RES_ACK    = 2'd0,
      RES_HEADER = 2'd1,
      RES_PIXEL  = 2'd2,
      RES_IDLE   = 2'd3
   } res_kind_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_OOB   = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_BUSY  = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'd0,
      CSR_FRAME_HEIGHT = 1'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC
   } ctrl_state_type;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic execute;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic out_busy;
   } dp_stat_type;

endpackage

### sv/drff_ctrl.sv
module drff_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  drff_pkg::dp_stat_type  stat,
   output drff_pkg::ctrl_cmd_type cmd
);

   drff_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= drff_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_ready      = 1'b0;
      unique case (state_ff)
         drff_pkg::S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) begin
               state_in = drff_pkg::S_IDLE;
            end
         end
         drff_pkg::S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = drff_pkg::S_EXEC;
            end
         end
         drff_pkg::S_EXEC: begin
            // hold until the output register can take the word
            if (!stat.out_busy) begin
               cmd.execute = 1'b1;
               state_in    = drff_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = drff_pkg::S_CLEAR;
         end
      endcase
   end

endmodule

### sv/drff_dp.sv
module drff_dp #(
   parameter int MAX_WIDTH  = drff_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = drff_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  drff_pkg::ctrl_cmd_type              cmd,
   output drff_pkg::dp_stat_type               stat,
   input  logic [1:0]                          req_kind,
   input  logic signed [drff_pkg::POS_W-1:0]   req_pos_x,
   input  logic signed [drff_pkg::POS_W-1:0]   req_pos_y,
   input  logic [drff_pkg::COLOR_W-1:0]        req_color,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_result_kind,
   output logic [1:0]                          rsp_status,
   output logic [drff_pkg::XW-1:0]             rsp_rect_min_x,
   output logic [drff_pkg::YW-1:0]             rsp_rect_min_y,
   output logic [drff_pkg::XW-1:0]             rsp_rect_max_x,
   output logic [drff_pkg::YW-1:0]             rsp_rect_max_y,
   output logic [drff_pkg::PIX_W-1:0]          rsp_pixel_565,
   output logic                                rsp_last,
   input  logic                                csr_we,
   input  logic [drff_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [drff_pkg::XW-1:0]             csr_wdata
);

   localparam int XW    = drff_pkg::XW;
   localparam int YW    = drff_pkg::YW;
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SUMW  = XW + YW + 1;

   function automatic logic [drff_pkg::PIX_W-1:0] to565(input logic [31:0] c);
      to565 = {c[31:27], c[23:18], c[15:11]};
   endfunction

   logic [31:0] mem [DEPTH];
   logic [31:0] rdata_ff;

   logic [XW-1:0] fw_ff, ew;
   logic [YW-1:0] fh_ff, eh;

   logic [XW-1:0] dmin_x_ff, dmax_x_ff;
   logic [YW-1:0] dmin_y_ff, dmax_y_ff;
   logic          dvalid_ff;

   logic [XW-1:0] tmin_x_ff, tmax_x_ff;
   logic [YW-1:0] tmax_y_ff;
   logic          pend_ff;
   logic [AW-1:0] cur_addr_ff;
   logic [XW-1:0] cur_x_ff;
   logic [YW-1:0] cur_y_ff;

   drff_pkg::req_kind_type kind_ff;
   logic [XW-1:0]          x_ff;
   logic [YW-1:0]          y_ff;
   logic [31:0]            color_ff;
   logic [AW-1:0]          addr_ff;
   logic                   oob_ff;

   logic [AW-1:0] clr_cnt_ff;

   logic                 out_valid_ff;
   drff_pkg::res_kind_type out_kind_ff;
   drff_pkg::status_type   out_stat_ff;
   logic [XW-1:0]        out_min_x_ff, out_max_x_ff;
   logic [YW-1:0]        out_min_y_ff, out_max_y_ff;
   logic [drff_pkg::PIX_W-1:0] out_pix_ff;
   logic                 out_last_ff;

   // effective panel size, clamped to 1..MAX
   always_comb begin
      if (fw_ff == '0) begin
         ew = XW'(1);
      end else if (int'(fw_ff) > MAX_WIDTH) begin
         ew = XW'(MAX_WIDTH);
      end else begin
         ew = fw_ff;
      end
      if (fh_ff == '0) begin
         eh = YW'(1);
      end else if (int'(fh_ff) > MAX_HEIGHT) begin
         eh = YW'(MAX_HEIGHT);
      end else begin
         eh = fh_ff;
      end
   end

   // address of the incoming item; a flush reuses the multiplier for its start address
   logic [15:0]     ux, uy;
   logic            oob;
   logic [XW-1:0]   mul_x;
   logic [YW-1:0]   mul_y;
   logic [SUMW-1:0] prod;
   logic [AW-1:0]   rd_addr;

   always_comb begin
      ux  = $unsigned(req_pos_x);
      uy  = $unsigned(req_pos_y);
      oob = ux[15] | uy[15] | (ux >= 16'(ew)) | (uy >= 16'(eh));
      if (drff_pkg::req_kind_type'(req_kind) == drff_pkg::KIND_FLUSH) begin
         mul_x = dmin_x_ff;
         mul_y = dmin_y_ff;
      end else begin
         mul_x = ux[XW-1:0];
         mul_y = uy[YW-1:0];
      end
      prod = SUMW'(mul_y) * SUMW'(ew) + SUMW'(mul_x);
      if (drff_pkg::req_kind_type'(req_kind) == drff_pkg::KIND_TICK) begin
         rd_addr = cur_addr_ff;
      end else begin
         rd_addr = AW'(prod);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff  <= drff_pkg::req_kind_type'(req_kind);
         x_ff     <= ux[XW-1:0];
         y_ff     <= uy[YW-1:0];
         color_ff <= req_color;
         addr_ff  <= rd_addr;
         oob_ff   <= oob;
      end
   end

   // pixel store
   logic wr_en;
   assign wr_en = cmd.execute && (kind_ff == drff_pkg::KIND_WRITE) && !oob_ff
                  && (rdata_ff != color_ff);

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         mem[clr_cnt_ff] <= '0;
      end else if (wr_en) begin
         mem[addr_ff] <= color_ff;
      end
      if (cmd.accept) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_cnt_ff <= clr_cnt_ff + AW'(1);
      end
   end

   assign stat.clear_done = (clr_cnt_ff == AW'(DEPTH - 1));
   assign stat.out_busy   = out_valid_ff && !rsp_ready;

   // tick cursor arithmetic
   logic          at_row_end, at_last;
   logic [AW-1:0] row_next_addr;

   assign at_row_end    = (cur_x_ff >= tmax_x_ff);
   assign at_last       = at_row_end && (cur_y_ff >= tmax_y_ff);
   assign row_next_addr = cur_addr_ff + AW'(ew) + AW'(tmin_x_ff) - AW'(cur_x_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff        <= drff_pkg::FRAME_WIDTH_RESET;
         fh_ff        <= drff_pkg::FRAME_HEIGHT_RESET;
         dmin_x_ff    <= drff_pkg::FRAME_WIDTH_RESET - XW'(1);
         dmin_y_ff    <= drff_pkg::FRAME_HEIGHT_RESET - YW'(1);
         dmax_x_ff    <= '0;
         dmax_y_ff    <= '0;
         dvalid_ff    <= 1'b0;
         tmin_x_ff    <= '0;
         tmax_x_ff    <= '0;
         tmax_y_ff    <= '0;
         pend_ff      <= 1'b0;
         cur_addr_ff  <= '0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && rsp_ready) begin
            out_valid_ff <= 1'b0;
         end

         if (csr_we) begin
            unique case (drff_pkg::csr_index_type'(csr_index))
               drff_pkg::CSR_FRAME_WIDTH:  fw_ff <= csr_wdata;
               drff_pkg::CSR_FRAME_HEIGHT: fh_ff <= csr_wdata[YW-1:0];
               default: ;
            endcase
            // drop the dirty box and cancel any transfer
            dmin_x_ff   <= ew - XW'(1);
            dmin_y_ff   <= eh - YW'(1);
            dmax_x_ff   <= '0;
            dmax_y_ff   <= '0;
            dvalid_ff   <= 1'b0;
            pend_ff     <= 1'b0;
            tmin_x_ff   <= '0;
            tmax_x_ff   <= '0;
            tmax_y_ff   <= '0;
            cur_addr_ff <= '0;
            cur_x_ff    <= '0;
            cur_y_ff    <= '0;
         end else if (cmd.execute) begin
            out_valid_ff <= 1'b1;
            out_stat_ff  <= drff_pkg::STAT_OK;
            out_min_x_ff <= '0;
            out_min_y_ff <= '0;
            out_max_x_ff <= '0;
            out_max_y_ff <= '0;
            out_pix_ff   <= '0;
            out_last_ff  <= 1'b0;
            unique case (kind_ff)
               drff_pkg::KIND_WRITE: begin
                  out_kind_ff <= drff_pkg::RES_ACK;
                  if (oob_ff) begin
                     out_stat_ff <= drff_pkg::STAT_OOB;
                  end else if (wr_en) begin
                     if (!dvalid_ff) begin
                        dmin_x_ff <= x_ff;
                        dmax_x_ff <= x_ff;
                        dmin_y_ff <= y_ff;
                        dmax_y_ff <= y_ff;
                        dvalid_ff <= 1'b1;
                     end else begin
                        if (x_ff < dmin_x_ff) dmin_x_ff <= x_ff;
                        if (x_ff > dmax_x_ff) dmax_x_ff <= x_ff;
                        if (y_ff < dmin_y_ff) dmin_y_ff <= y_ff;
                        if (y_ff > dmax_y_ff) dmax_y_ff <= y_ff;
                     end
                  end
               end
               drff_pkg::KIND_FLUSH: begin
                  out_kind_ff <= drff_pkg::RES_HEADER;
                  if (pend_ff) begin
                     out_stat_ff <= drff_pkg::STAT_BUSY;
                  end else if (!dvalid_ff) begin
                     out_stat_ff <= drff_pkg::STAT_EMPTY;
                  end else begin
                     out_min_x_ff <= dmin_x_ff;
                     out_min_y_ff <= dmin_y_ff;
                     out_max_x_ff <= dmax_x_ff;
                     out_max_y_ff <= dmax_y_ff;
                     tmin_x_ff    <= dmin_x_ff;
                     tmax_x_ff    <= dmax_x_ff;
                     tmax_y_ff    <= dmax_y_ff;
                     cur_addr_ff  <= addr_ff;
                     cur_x_ff     <= dmin_x_ff;
                     cur_y_ff     <= dmin_y_ff;
                     pend_ff      <= 1'b1;
                     dmin_x_ff    <= ew - XW'(1);
                     dmin_y_ff    <= eh - YW'(1);
                     dmax_x_ff    <= '0;
                     dmax_y_ff    <= '0;
                     dvalid_ff    <= 1'b0;
                  end
               end
               drff_pkg::KIND_TICK: begin
                  if (pend_ff) begin
                     out_kind_ff <= drff_pkg::RES_PIXEL;
                     out_pix_ff  <= to565(rdata_ff);
                     if (at_last) begin
                        out_last_ff <= 1'b1;
                        pend_ff     <= 1'b0;
                        cur_addr_ff <= '0;
                     end else if (at_row_end) begin
                        cur_addr_ff <= row_next_addr;
                        cur_x_ff    <= tmin_x_ff;
                        cur_y_ff    <= cur_y_ff + YW'(1);
                     end else begin
                        cur_addr_ff <= cur_addr_ff + AW'(1);
                        cur_x_ff    <= cur_x_ff + XW'(1);
                     end
                  end else begin
                     out_kind_ff <= drff_pkg::RES_IDLE;
                  end
               end
               drff_pkg::KIND_NONE: begin
                  out_kind_ff <= drff_pkg::RES_IDLE;
               end
               default: begin
                  out_kind_ff <= drff_pkg::RES_IDLE;
               end
            endcase
         end
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_kind = out_kind_ff;
   assign rsp_status      = out_stat_ff;
   assign rsp_rect_min_x  = out_min_x_ff;
   assign rsp_rect_min_y  = out_min_y_ff;
   assign rsp_rect_max_x  = out_max_x_ff;
   assign rsp_rect_max_y  = out_max_y_ff;
   assign rsp_pixel_565   = out_pix_ff;
   assign rsp_last        = out_last_ff;

   a_cursor_in_box: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (cur_x_ff <= tmax_x_ff) && (cur_y_ff <= tmax_y_ff))
      else $error("transfer cursor left the latched box");

   a_dirty_ordered: assert property (@(posedge clock) disable iff (reset)
      dvalid_ff |-> (dmin_x_ff <= dmax_x_ff) && (dmin_y_ff <= dmax_y_ff))
      else $error("dirty box corners out of order");

   a_exec_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |-> !(out_valid_ff && !rsp_ready))
      else $error("result produced over a waiting word");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_step, cmd.accept, cmd.execute}))
      else $error("more than one datapath command at once");

   a_cursor_addr: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (int'(cur_addr_ff) < DEPTH))
      else $error("transfer address beyond the pixel store");

endmodule

### sv/dirty_rect_framebuffer_flush.sv
// Dirty-rectangle framebuffer with raster-order region transfer.
//
// Request channel (req_*): kind 0 writes req_color at (req_pos_x, req_pos_y),
// kind 1 flushes the dirty box, kind 2 ticks out the next pixel of a running
// transfer. Every accepted word gives exactly one result word on rsp_*.
// Config port (csr_*): index 0 frame width, index 1 frame height; a write
// empties the dirty box and cancels a transfer. Write it only while idle.
//
// A new request is taken only after the last one has executed; the pixel
// memory is read at the accept edge and written back (on a color change)
// in the execute cycle, whose result word is loaded into the output register.
// While a result waits, the next request is still accepted; the block then
// holds in execute until the output register is taken.
//
// After reset the pixel store is swept to black, one word per cycle, across
// all MAX_WIDTH * MAX_HEIGHT words; req_ready stays low until the sweep
// ends, while config writes are taken as usual.
module dirty_rect_framebuffer_flush #(
   parameter int MAX_WIDTH  = drff_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = drff_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_kind,
   input  logic signed [drff_pkg::POS_W-1:0]   req_pos_x,
   input  logic signed [drff_pkg::POS_W-1:0]   req_pos_y,
   input  logic [drff_pkg::COLOR_W-1:0]        req_color,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_result_kind,
   output logic [1:0]                          rsp_status,
   output logic [drff_pkg::XW-1:0]             rsp_rect_min_x,
   output logic [drff_pkg::YW-1:0]             rsp_rect_min_y,
   output logic [drff_pkg::XW-1:0]             rsp_rect_max_x,
   output logic [drff_pkg::YW-1:0]             rsp_rect_max_y,
   output logic [drff_pkg::PIX_W-1:0]          rsp_pixel_565,
   output logic                                rsp_last,
   input  logic                                csr_we,
   input  logic [drff_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [drff_pkg::XW-1:0]             csr_wdata
);

   drff_pkg::ctrl_cmd_type cmd;
   drff_pkg::dp_stat_type  stat;

   drff_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   drff_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_kind        (req_kind),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_color       (req_color),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_status      (rsp_status),
      .rsp_rect_min_x  (rsp_rect_min_x),
      .rsp_rect_min_y  (rsp_rect_min_y),
      .rsp_rect_max_x  (rsp_rect_max_x),
      .rsp_rect_max_y  (rsp_rect_max_y),
      .rsp_pixel_565   (rsp_pixel_565),
      .rsp_last        (rsp_last),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

endmodule

### tb/dirty_rect_framebuffer_flush_tb.sv
`timescale 1ns / 100ps

module dirty_rect_framebuffer_flush_tb;

   localparam int XW          = drff_pkg::XW;
   localparam int YW          = drff_pkg::YW;
   localparam int PIX_W       = drff_pkg::PIX_W;
   localparam int POS_W       = drff_pkg::POS_W;
   localparam int COLOR_W     = drff_pkg::COLOR_W;
   localparam int CSR_IDX_W   = drff_pkg::CSR_IDX_W;
   localparam int PANEL_W     = drff_pkg::MAX_WIDTH_DEFAULT;
   localparam int PANEL_H     = drff_pkg::MAX_HEIGHT_DEFAULT;
   localparam int STORE_WORDS = PANEL_W * PANEL_H;
   localparam int STALL_MAX   = 12;
   localparam int PHASE_ITEMS = 100;
   // covers the sweep of the pixel store after reset with room to spare
   localparam int QUIET_LIMIT = 4 * STORE_WORDS;

   typedef struct {
      drff_pkg::res_kind_type kind;
      drff_pkg::status_type   status;
      logic [XW-1:0]          min_x;
      logic [YW-1:0]          min_y;
      logic [XW-1:0]          max_x;
      logic [YW-1:0]          max_y;
      logic [PIX_W-1:0]       pixel;
      logic                   last;
   } panel_word_type;

   class flush_scoreboard_type;
      logic [COLOR_W-1:0] store [STORE_WORDS];
      logic [XW-1:0]      width_reg;
      logic [YW-1:0]      height_reg;
      logic [XW-1:0]      dirty_x0, dirty_x1;
      logic [YW-1:0]      dirty_y0, dirty_y1;
      bit                 dirty;
      logic [XW-1:0]      span_x0, span_x1;
      logic [YW-1:0]      span_y1;
      logic [16:0]        cursor;
      bit                 streaming;
      panel_word_type     due [$];
      int errors = 0;
      int checked = 0;
      int regions = 0;
      int pixels = 0;
      int rejects = 0;
      int refusals = 0;

      function new();
         foreach (store[i]) store[i] = '0;
         width_reg  = drff_pkg::FRAME_WIDTH_RESET;
         height_reg = drff_pkg::FRAME_HEIGHT_RESET;
         streaming  = 1'b0;
         cursor     = '0;
         clear_box();
      endfunction

      function int cols();
         if (width_reg == 0) return 1;
         if (width_reg > PANEL_W) return PANEL_W;
         return width_reg;
      endfunction

      function int rows();
         if (height_reg == 0) return 1;
         if (height_reg > PANEL_H) return PANEL_H;
         return height_reg;
      endfunction

      function void clear_box();
         dirty_x0 = XW'(cols() - 1);
         dirty_y0 = YW'(rows() - 1);
         dirty_x1 = '0;
         dirty_y1 = '0;
         dirty    = 1'b0;
      endfunction

      // a register write empties the box and drops any transfer; pixels stay
      function void set_reg(drff_pkg::csr_index_type idx, logic [XW-1:0] val);
         if (idx == drff_pkg::CSR_FRAME_WIDTH) width_reg = val;
         else height_reg = val[YW-1:0];
         clear_box();
         streaming = 1'b0;
         cursor    = '0;
      endfunction

      function void note(drff_pkg::req_kind_type k, logic [POS_W-1:0] x,
                         logic [POS_W-1:0] y, logic [COLOR_W-1:0] c);
         panel_word_type     r;
         int                 w, h, addr, cur, cx, cy;
         logic [COLOR_W-1:0] word;
         w = cols();
         h = rows();
         r.kind   = drff_pkg::RES_IDLE;
         r.status = drff_pkg::STAT_OK;
         r.min_x  = '0;
         r.min_y  = '0;
         r.max_x  = '0;
         r.max_y  = '0;
         r.pixel  = '0;
         r.last   = 1'b0;
         case (k)
            drff_pkg::KIND_WRITE: begin
               r.kind = drff_pkg::RES_ACK;
               if (x[POS_W-1] || y[POS_W-1] || x >= w || y >= h) begin
                  r.status = drff_pkg::STAT_OOB;
                  rejects++;
               end else begin
                  addr = y * w + x;
                  if (store[addr] !== c) begin
                     store[addr] = c;
                     if (!dirty) begin
                        dirty_x0 = x[XW-1:0];
                        dirty_x1 = x[XW-1:0];
                        dirty_y0 = y[YW-1:0];
                        dirty_y1 = y[YW-1:0];
                        dirty    = 1'b1;
                     end else begin
                        if (x < dirty_x0) dirty_x0 = x[XW-1:0];
                        if (x > dirty_x1) dirty_x1 = x[XW-1:0];
                        if (y < dirty_y0) dirty_y0 = y[YW-1:0];
                        if (y > dirty_y1) dirty_y1 = y[YW-1:0];
                     end
                  end
               end
            end
            drff_pkg::KIND_FLUSH: begin
               r.kind = drff_pkg::RES_HEADER;
               if (streaming) begin
                  r.status = drff_pkg::STAT_BUSY;
                  refusals++;
               end else if (!dirty) begin
                  r.status = drff_pkg::STAT_EMPTY;
               end else begin
                  span_x0   = dirty_x0;
                  span_x1   = dirty_x1;
                  span_y1   = dirty_y1;
                  cursor    = 17'(dirty_y0 * w + dirty_x0);
                  streaming = 1'b1;
                  r.min_x   = dirty_x0;
                  r.min_y   = dirty_y0;
                  r.max_x   = dirty_x1;
                  r.max_y   = dirty_y1;
                  regions++;
                  clear_box();
               end
            end
            drff_pkg::KIND_TICK: begin
               if (streaming) begin
                  cur = cursor;
                  if (cur >= STORE_WORDS) cur = 0;
                  cx   = cur % w;
                  cy   = cur / w;
                  word = store[cur];
                  r.kind  = drff_pkg::RES_PIXEL;
                  r.pixel = {word[31:27], word[23:18], word[15:11]};
                  pixels++;
                  if (cx >= span_x1 && cy >= span_y1) begin
                     r.last    = 1'b1;
                     streaming = 1'b0;
                     cursor    = '0;
                  end else if (cx >= span_x1) begin
                     cursor = 17'((cy + 1) * w + span_x0);
                  end else begin
                     cursor = 17'(cur + 1);
                  end
               end
            end
            default: ;
         endcase
         due.insert(due.size(), r);
      endfunction

      task report(string what);
         errors++;
         if (errors <= 40) $display("%0t ns  mismatch: %s", $time, what);
      endtask

      task check(panel_word_type got);
         panel_word_type want;
         if (due.size() == 0) begin
            report("result word with nothing outstanding");
            return;
         end
         want = due.pop_front();
         checked++;
         if (got.kind !== want.kind)
            report($sformatf("result_kind %0d, want %0d", got.kind, want.kind));
         if (got.status !== want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.min_x !== want.min_x)
            report($sformatf("rect_min_x %0d, want %0d", got.min_x, want.min_x));
         if (got.min_y !== want.min_y)
            report($sformatf("rect_min_y %0d, want %0d", got.min_y, want.min_y));
         if (got.max_x !== want.max_x)
            report($sformatf("rect_max_x %0d, want %0d", got.max_x, want.max_x));
         if (got.max_y !== want.max_y)
            report($sformatf("rect_max_y %0d, want %0d", got.max_y, want.max_y));
         if (got.pixel !== want.pixel)
            report($sformatf("pixel_565 %h, want %h", got.pixel, want.pixel));
         if (got.last !== want.last)
            report($sformatf("last %b, want %b", got.last, want.last));
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_kind = drff_pkg::KIND_WRITE;
   logic [POS_W-1:0]   req_pos_x = '0;
   logic [POS_W-1:0]   req_pos_y = '0;
   logic [COLOR_W-1:0] req_color = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_result_kind;
   logic [1:0]         rsp_status;
   logic [XW-1:0]      rsp_rect_min_x;
   logic [YW-1:0]      rsp_rect_min_y;
   logic [XW-1:0]      rsp_rect_max_x;
   logic [YW-1:0]      rsp_rect_max_y;
   logic [PIX_W-1:0]   rsp_pixel_565;
   logic               rsp_last;
   logic               csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = drff_pkg::CSR_FRAME_WIDTH;
   logic [XW-1:0]      csr_wdata = '0;

   flush_scoreboard_type sb;
   bit                 send_calm = 1'b0;
   int                 sent = 0;
   int                 settings = 1;
   int                 win_x, win_y, win_w, win_h;
   logic [COLOR_W-1:0] palette [4];
   int                 quiet = 0;

   dirty_rect_framebuffer_flush dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_color       (req_color),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_status      (rsp_status),
      .rsp_rect_min_x  (rsp_rect_min_x),
      .rsp_rect_min_y  (rsp_rect_min_y),
      .rsp_rect_max_x  (rsp_rect_max_x),
      .rsp_rect_max_y  (rsp_rect_max_y),
      .rsp_pixel_565   (rsp_pixel_565),
      .rsp_last        (rsp_last),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #2 clock = ~clock;

   // called at a rising edge; returns at the edge where the word was taken
   task automatic push_word(input drff_pkg::req_kind_type k, input logic [POS_W-1:0] x,
                            input logic [POS_W-1:0] y, input logic [COLOR_W-1:0] c);
      int gap;
      if ($urandom_range(0, 24) == 0) send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, STALL_MAX);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= k;
      req_pos_x <= x;
      req_pos_y <= y;
      req_color <= c;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note(k, x, y, c);
      sent++;
   endtask

   // hold the request side until every outstanding word has come back
   task automatic hold_off();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.due.size() != 0);
   endtask

   task automatic write_reg(input drff_pkg::csr_index_type idx, input logic [XW-1:0] val);
      hold_off();
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
      csr_we <= 1'b0;
   endtask

   function automatic void pick_window(input int w, input int h);
      win_x = $urandom_range(0, w - 1);
      win_y = $urandom_range(0, h - 1);
      win_w = $urandom_range(1, 8);
      win_h = $urandom_range(1, 6);
      if (win_w > w - win_x) win_w = w - win_x;
      if (win_h > h - win_y) win_h = h - win_y;
   endfunction

   task automatic directed_items();
      push_word(drff_pkg::KIND_TICK, '0, '0, '0);
      push_word(drff_pkg::KIND_NONE, '1, '1, '1);
      push_word(drff_pkg::KIND_FLUSH, '0, '0, '0);
      push_word(drff_pkg::KIND_WRITE, 16'd0, 16'd0, 32'h0);
      push_word(drff_pkg::KIND_WRITE, 16'h8000, 16'd0, '1);
      push_word(drff_pkg::KIND_WRITE, 16'h7FFF, 16'd5, '1);
      push_word(drff_pkg::KIND_WRITE, 16'd3, 16'hFFFF, '1);
      push_word(drff_pkg::KIND_WRITE, 16'd320, 16'd0, '1);
      push_word(drff_pkg::KIND_WRITE, 16'd0, 16'd240, '1);
      push_word(drff_pkg::KIND_WRITE, 16'd319, 16'd239, '1);
      push_word(drff_pkg::KIND_FLUSH, '0, '0, '0);
      push_word(drff_pkg::KIND_FLUSH, '1, '1, '1);
      // alpha-only change under the cursor: streamed as black, dirties the corner again
      push_word(drff_pkg::KIND_WRITE, 16'd319, 16'd239, 32'h0000_00FF);
      push_word(drff_pkg::KIND_TICK, '1, '1, '1);
      push_word(drff_pkg::KIND_TICK, '0, '0, '0);
      push_word(drff_pkg::KIND_FLUSH, '0, '0, '0);
      push_word(drff_pkg::KIND_TICK, '0, '0, '0);
      push_word(drff_pkg::KIND_WRITE, 16'd2, 16'd3, 32'h1234_5678);
      push_word(drff_pkg::KIND_WRITE, 16'd4, 16'd4, 32'h8040_20A5);
      push_word(drff_pkg::KIND_WRITE, 16'd4, 16'd4, 32'h8040_20A5);
      push_word(drff_pkg::KIND_FLUSH, '0, '0, '0);
      push_word(drff_pkg::KIND_TICK, '0, '0, '0);
      push_word(drff_pkg::KIND_WRITE, 16'd3, 16'd4, 32'hF8FC_F800);
      repeat (5) push_word(drff_pkg::KIND_TICK, '0, '0, '0);
   endtask

   task automatic random_phase(input int n);
      int                 w, h, roll;
      bit                 was_streaming;
      logic [COLOR_W-1:0] c;
      w = sb.cols();
      h = sb.rows();
      palette[0] = '0;
      palette[1] = '1;
      palette[2] = $urandom;
      palette[3] = $urandom;
      pick_window(w, h);
      was_streaming = sb.streaming;
      for (int i = 0; i < n; i++) begin
         if (was_streaming && !sb.streaming) pick_window(w, h);
         was_streaming = sb.streaming;
         if ($urandom_range(0, 59) == 0) hold_off();
         roll = $urandom_range(0, 99);
         c = ($urandom_range(0, 9) < 7) ? palette[$urandom_range(0, 3)] : $urandom;
         if (roll < 8) begin
            case (roll % 4)
               0: push_word(drff_pkg::KIND_WRITE, 16'($urandom), 16'($urandom), c);
               1: push_word(drff_pkg::KIND_WRITE, 16'(w + $urandom_range(0, 3)),
                            16'($urandom_range(0, h - 1)), c);
               2: push_word(drff_pkg::KIND_WRITE, 16'($urandom_range(0, w - 1)),
                            16'(h + $urandom_range(0, 3)), c);
               default: push_word(drff_pkg::req_kind_type'($urandom_range(1, 3)),
                                  16'($urandom), 16'($urandom), $urandom);
            endcase
         end else if (sb.streaming && roll < 75) begin
            push_word(drff_pkg::KIND_TICK, 16'($urandom), 16'($urandom), $urandom);
         end else if (roll < 22) begin
            push_word(drff_pkg::KIND_FLUSH, 16'($urandom), 16'($urandom), $urandom);
         end else begin
            push_word(drff_pkg::KIND_WRITE, 16'(win_x + $urandom_range(0, win_w - 1)),
                      16'(win_y + $urandom_range(0, win_h - 1)), c);
         end
      end
   endtask

   initial begin : result_side
      panel_word_type got;
      int             stall;
      bit             calm;
      calm = 1'b0;
      forever begin
         if ($urandom_range(0, 24) == 0) calm = !calm;
         stall = calm ? 0 : $urandom_range(0, STALL_MAX);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got.kind   = drff_pkg::res_kind_type'(rsp_result_kind);
         got.status = drff_pkg::status_type'(rsp_status);
         got.min_x  = rsp_rect_min_x;
         got.min_y  = rsp_rect_min_y;
         got.max_x  = rsp_rect_max_x;
         got.max_y  = rsp_rect_max_y;
         got.pixel  = rsp_pixel_565;
         got.last   = rsp_last;
         sb.check(got);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("%0t ns  no word moved for %0d cycles", $time, quiet);
         $display("dirty_rect_framebuffer_flush regression: fail");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      directed_items();
      random_phase(PHASE_ITEMS);

      write_reg(drff_pkg::CSR_FRAME_WIDTH, 9'd1);
      write_reg(drff_pkg::CSR_FRAME_HEIGHT, 9'd1);
      random_phase(PHASE_ITEMS);

      // height is masked to eight bits, then clamped
      write_reg(drff_pkg::CSR_FRAME_WIDTH, 9'h1FF);
      write_reg(drff_pkg::CSR_FRAME_HEIGHT, 9'h1FF);
      random_phase(PHASE_ITEMS);

      write_reg(drff_pkg::CSR_FRAME_WIDTH, 9'd0);
      write_reg(drff_pkg::CSR_FRAME_HEIGHT, 9'd7);
      random_phase(PHASE_ITEMS);

      write_reg(drff_pkg::CSR_FRAME_WIDTH, 9'd23);
      write_reg(drff_pkg::CSR_FRAME_HEIGHT, 9'd0);
      random_phase(PHASE_ITEMS);

      write_reg(drff_pkg::CSR_FRAME_WIDTH, 9'($urandom_range(2, 64)));
      write_reg(drff_pkg::CSR_FRAME_HEIGHT, 9'($urandom_range(2, 48)));
      random_phase(PHASE_ITEMS);

      write_reg(drff_pkg::CSR_FRAME_WIDTH, 9'd320);
      write_reg(drff_pkg::CSR_FRAME_HEIGHT, 9'd240);
      random_phase(PHASE_ITEMS);
      settings = 7;

      hold_off();
      repeat (8) @(posedge clock);
      if (sb.due.size() != 0)
         sb.report($sformatf("%0d result words never arrived", sb.due.size()));

      $display("%0d request words over %0d panel sizes, %0d result words checked",
               sent, settings, sb.checked);
      $display("%0d regions flushed, %0d pixels streamed, %0d writes rejected, %0d busy",
               sb.regions, sb.pixels, sb.rejects, sb.refusals);
      if (sb.errors == 0) begin
         $display("dirty_rect_framebuffer_flush regression: pass");
      end else begin
         $display("dirty_rect_framebuffer_flush regression: fail");
      end
      $finish;
   end

endmodule

### filelist.f
sv/drff_pkg.sv
sv/drff_ctrl.sv
sv/drff_dp.sv
sv/dirty_rect_framebuffer_flush.sv
tb/dirty_rect_framebuffer_flush_tb.sv
